// ===== sv/round_trip_loss_bit_tracker_macros.svh =====
// Assertion macros for the round-trip loss-bit tracker.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ROUND_TRIP_LOSS_BIT_TRACKER_MACROS_SVH
`define ROUND_TRIP_LOSS_BIT_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RTLT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTLT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rtlt_pkg.sv =====
// Shared types and constants of the round-trip loss-bit tracker.
// No dependencies.
package rtlt_pkg;

	localparam int RATE_W = 17;
	localparam logic [RATE_W-1:0] RATE_ONE = 17'h10000;
	localparam logic [RATE_W-1:0] MAX_RATE_RESET = 17'h10000;
	localparam int HISTORY_DEPTH_D = 8;
	localparam int COUNT_WIDTH_D = 32;
	localparam int FRAC_BITS = 16;

	// Result event codes.
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_TOTAL = 2'd1;
	localparam logic [1:0] EV_FULL = 2'd2;

	typedef struct packed {
		logic direction;
		logic spin_flip;
		logic loss_bit;
	} in_item_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic out_direction;
		logic [RATE_W-1:0] total_loss_rate;
		logic [RATE_W-1:0] average_loss_rate;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_H_START,
		ST_H_WAIT,
		ST_T_START,
		ST_T_WAIT,
		ST_WALK,
		ST_A_START,
		ST_A_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_item;
		logic eval;
		logic hdiv_start;
		logic hdiv_store;
		logic tdiv_start;
		logic tdiv_store;
		logic walk;
		logic adiv_start;
		logic adiv_store;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] ev;
		logic full_q;
		logic frac_done;
		logic walk_last;
		logic avg_done;
	} status_t;

endpackage

// ===== sv/rtlt_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing; used for rate fractions and the history average.
module rtlt_div #(
	parameter int REM_W = 32,
	parameter int DVD_W = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [REM_W-1:0] init_rem,
	input  logic [DVD_W-1:0] dividend,
	input  logic [REM_W-1:0] divisor,
	output logic done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] den_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic ge;

	// One trial subtraction per cycle.
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= init_rem;
			den_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/rtlt_ctrl.sv =====
// Controller state machine of the round-trip loss-bit tracker.
// Depends on rtlt_pkg; drives the datapath through cmd_t, reads status_t.
module rtlt_ctrl
	import rtlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  status_t status,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EVAL;
			ST_EVAL: begin
				if (status.ev == EV_FULL) state_d = ST_H_START;
				else if (status.ev == EV_TOTAL) state_d = ST_T_START;
				else state_d = ST_FINISH;
			end
			ST_H_START: state_d = ST_H_WAIT;
			ST_H_WAIT: if (status.frac_done) state_d = ST_T_START;
			ST_T_START: state_d = ST_T_WAIT;
			ST_T_WAIT: begin
				if (status.frac_done) state_d = status.full_q ? ST_WALK : ST_FINISH;
			end
			ST_WALK: if (status.walk_last) state_d = ST_A_START;
			ST_A_START: state_d = ST_A_WAIT;
			ST_A_WAIT: if (status.avg_done) state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_EVAL: cmd.eval = 1'b1;
			ST_H_START: cmd.hdiv_start = 1'b1;
			ST_H_WAIT: cmd.hdiv_store = status.frac_done;
			ST_T_START: cmd.tdiv_start = 1'b1;
			ST_T_WAIT: cmd.tdiv_store = status.frac_done;
			ST_WALK: cmd.walk = 1'b1;
			ST_A_START: cmd.adiv_start = 1'b1;
			ST_A_WAIT: cmd.adiv_store = status.avg_done;
			ST_FINISH: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/rtlt_dp.sv =====
// Datapath of the round-trip loss-bit tracker: per-direction counters,
// rate history, two serial dividers and the result register.
// Depends on rtlt_pkg and rtlt_div.
module rtlt_dp
	import rtlt_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_D,
	parameter int COUNT_WIDTH = COUNT_WIDTH_D
) (
	input  logic clk,
	input  logic arst_n,
	input  in_item_t in_data,
	input  logic cfg_valid,
	input  logic [RATE_W-1:0] cfg_data,
	input  cmd_t cmd,
	output status_t status,
	output out_item_t out_data
);

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = RATE_W + $clog2(HISTORY_DEPTH + 1);
	localparam int CW = COUNT_WIDTH;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? {CW{1'b1}} : s[CW-1:0];
	endfunction

	// Item and configuration registers.
	logic dir_q, flip_q, mark_q;
	logic [RATE_W-1:0] max_rate_q;

	// Per-direction tracker state.
	logic pe_q [2];
	logic rp_q [2];
	logic [CW-1:0] cur_q [2];
	logic [CW-1:0] prev_q [2];
	logic [CW-1:0] lost_q [2];
	logic [CW-1:0] mk_q [2];
	logic [CW-1:0] gen_q [2];
	logic [PTR_W-1:0] ptr_q [2];
	logic [RATE_W-1:0] total_q [2];
	logic [RATE_W-1:0] avg_q [2];
	logic [RATE_W-1:0] hist_q [2][HISTORY_DEPTH];

	// Division operands captured at evaluation.
	logic [CW-1:0] hnum_q, hden_q, tnum_q, tden_q;
	logic [1:0] ev_q;

	// History walk.
	logic [PTR_W-1:0] widx_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] n_q;
	logic [RATE_W-1:0] entry;

	// Fraction unit.
	logic [CW-1:0] f_num, f_den;
	logic f_sp_q;
	logic [RATE_W-1:0] f_spv_q;
	logic f_done;
	logic [FRAC_BITS-1:0] f_quo;
	logic [RATE_W-1:0] f_res;
	logic a_done;
	logic [SUM_W-1:0] a_quo;
	out_item_t out_q;

	// Evaluation of one packet against the selected tracker.
	logic pe, rp, close, lt;
	logic [CW-1:0] cur, prv, lost, mk, gen, losses;
	logic [1:0] ev_c;
	logic [CW-1:0] lost_n, gen_n, prev_n, cur_f, cur_n, mk_n;
	logic rp_n, pe_f, pe_n;

	always_comb begin
		pe = pe_q[dir_q];
		rp = rp_q[dir_q];
		cur = cur_q[dir_q];
		prv = prev_q[dir_q];
		lost = lost_q[dir_q];
		mk = mk_q[dir_q];
		gen = gen_q[dir_q];
		close = flip_q && pe && (cur != '0);
		lt = prv < cur;
		losses = prv - cur;
		if (close && rp) ev_c = lt ? EV_TOTAL : EV_FULL;
		else ev_c = EV_NONE;
		lost_n = (close && rp) ? sat_add(lost, lt ? prv : losses) : lost;
		gen_n = (ev_c == EV_FULL) ? sat_add(gen, prv) : gen;
		rp_n = close ? ((rp && lt && (prv != '0)) ? 1'b1 : !rp) : rp;
		prev_n = close ? cur : prv;
		cur_f = close ? '0 : cur;
		pe_f = (flip_q && !pe) ? 1'b1 : pe;
		mk_n = mark_q ? sat_add(mk, CW'(1)) : mk;
		cur_n = mark_q ? sat_add(cur_f, CW'(1)) : cur_f;
		pe_n = mark_q ? 1'b0 : pe_f;
	end

	// Item capture, operands and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q <= MAX_RATE_RESET;
		end else if (cfg_valid) begin
			max_rate_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			dir_q <= in_data.direction;
			flip_q <= in_data.spin_flip;
			mark_q <= in_data.loss_bit;
		end
		if (cmd.eval) begin
			ev_q <= ev_c;
			hnum_q <= losses;
			hden_q <= prv;
			tnum_q <= lost_n;
			tden_q <= (ev_c == EV_FULL) ? gen_n : mk;
		end
	end

	// Tracker state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				pe_q[i] <= 1'b0;
				rp_q[i] <= 1'b0;
				cur_q[i] <= '0;
				prev_q[i] <= '0;
				lost_q[i] <= '0;
				mk_q[i] <= '0;
				gen_q[i] <= '0;
				ptr_q[i] <= '0;
				total_q[i] <= '0;
				avg_q[i] <= '0;
				for (int j = 0; j < HISTORY_DEPTH; j++) hist_q[i][j] <= '0;
			end
		end else begin
			if (cmd.eval) begin
				pe_q[dir_q] <= pe_n;
				rp_q[dir_q] <= rp_n;
				cur_q[dir_q] <= cur_n;
				prev_q[dir_q] <= prev_n;
				lost_q[dir_q] <= lost_n;
				mk_q[dir_q] <= mk_n;
				gen_q[dir_q] <= gen_n;
			end
			if (cmd.hdiv_store) begin
				hist_q[dir_q][ptr_q[dir_q]] <= f_res;
				if (ptr_q[dir_q] == PTR_W'(HISTORY_DEPTH - 1)) ptr_q[dir_q] <= '0;
				else ptr_q[dir_q] <= ptr_q[dir_q] + 1'b1;
			end
			if (cmd.tdiv_store) total_q[dir_q] <= f_res;
			if (cmd.adiv_store) avg_q[dir_q] <= (n_q == '0) ? '0 : a_quo[RATE_W-1:0];
		end
	end

	// Fraction unit: special cases are settled when the division starts.
	assign f_num = cmd.hdiv_start ? hnum_q : tnum_q;
	assign f_den = cmd.hdiv_start ? hden_q : tden_q;

	always_ff @(posedge clk) begin
		if (cmd.hdiv_start || cmd.tdiv_start) begin
			f_sp_q <= (f_den == '0) || (f_num >= f_den);
			f_spv_q <= (f_num == '0) ? '0 : RATE_ONE;
		end
	end

	rtlt_div #(
		.REM_W(CW),
		.DVD_W(FRAC_BITS)
	) u_frac (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.hdiv_start || cmd.tdiv_start),
		.init_rem(f_num),
		.dividend('0),
		.divisor(f_den),
		.done(f_done),
		.quotient(f_quo)
	);

	assign f_res = f_sp_q ? f_spv_q : {1'b0, f_quo};

	// History walk: one entry per cycle; entries below max_rate go into the running sum and count.
	assign entry = hist_q[dir_q][widx_q];

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			widx_q <= '0;
			sum_q <= '0;
			n_q <= '0;
		end else if (cmd.walk) begin
			widx_q <= widx_q + 1'b1;
			if (entry < max_rate_q) begin
				sum_q <= sum_q + SUM_W'(entry);
				n_q <= n_q + 1'b1;
			end
		end
	end

	rtlt_div #(
		.REM_W(CNT_W),
		.DVD_W(SUM_W)
	) u_avg (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.adiv_start),
		.init_rem('0),
		.dividend(sum_q),
		.divisor(n_q),
		.done(a_done),
		.quotient(a_quo)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.event_res <= ev_q;
			out_q.out_direction <= dir_q;
			out_q.total_loss_rate <= total_q[dir_q];
			out_q.average_loss_rate <= avg_q[dir_q];
		end
	end

	assign out_data = out_q;

	assign status.ev = ev_c;
	assign status.full_q = (ev_q == EV_FULL);
	assign status.frac_done = f_done;
	assign status.walk_last = (widx_q == PTR_W'(HISTORY_DEPTH - 1));
	assign status.avg_done = a_done;

endmodule

// ===== sv/round_trip_loss_bit_tracker.sv =====
// Round-trip loss-bit tracker, two directions with a shared datapath.
// Takes one observed packet per transfer on in_*: direction, spin_flip and
// loss_bit. Gives exactly one result per packet on out_*: the event code
// and the total and average loss rates held for that direction, in
// unsigned fixed point where 65536 stands for 1.0. max_rate is written by
// a transfer on cfg_*, which is always ready; write it only while idle.
// A packet that closes no period goes from evaluation straight to the
// result. When only the total rate is updated, the serial fraction
// divider runs once; a full measurement runs it twice, for the history
// rate and then the total rate, walks the history (one entry a cycle)
// and then runs the serial average divider. One packet is processed at
// a time; the next one is taken in the cycle after the result is loaded.
// A loaded result may still wait to be taken while the next packet is
// processed; if the receiver stalls, that next result waits in the
// controller. Reset clears all per-direction counters, history and held
// rates, and sets max_rate to 1.0.
// Depends on rtlt_pkg, rtlt_ctrl, rtlt_dp and the macro header.
`include "round_trip_loss_bit_tracker_macros.svh"

module round_trip_loss_bit_tracker
	import rtlt_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_D,
	parameter int COUNT_WIDTH = COUNT_WIDTH_D
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [RATE_W-1:0] cfg_data
);

	cmd_t cmd;
	status_t status;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	rtlt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.cmd(cmd)
	);

	rtlt_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status),
		.out_data(out_data)
	);

	// After taking a packet the block is busy evaluating it.
	`RTLT_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready && cmd.eval, "not evaluating after input transfer")
	// Only defined event codes leave the block.
	`RTLT_ASSERT_IMP(a_event_code, out_valid, out_data.event_res == EV_NONE || out_data.event_res == EV_TOTAL || out_data.event_res == EV_FULL, "undefined event code")
	// Rates never exceed 1.0.
	`RTLT_ASSERT_IMP(a_rate_range, out_valid, out_data.total_loss_rate <= RATE_ONE && out_data.average_loss_rate <= RATE_ONE, "rate above 1.0")

endmodule

// ===== verif/round_trip_loss_bit_tracker_tb.sv =====
// Testbench for the round-trip loss-bit tracker: drives packets and max_rate
// writes, predicts every result in a scoreboard class and checks each field.
// Depends on rtlt_pkg and the round_trip_loss_bit_tracker RTL.
module round_trip_loss_bit_tracker_tb;
	import rtlt_pkg::*;

	localparam int HDEPTH = 8;
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 20000;

	// Loss tracker predictor with its own copy of the per-direction state.
	class loss_scoreboard;
		logic [RATE_W-1:0] max_rate;
		bit empty_flag[2];
		bit reflecting[2];
		logic [31:0] cur_cnt[2], prev_cnt[2], lost_cnt[2], mark_cnt[2], gen_cnt[2];
		logic [RATE_W-1:0] ring[2][HDEPTH];
		int ring_ptr[2];
		logic [RATE_W-1:0] total_q[2], avg_q[2];
		out_item_t pending[$];
		int mismatches;

		function new();
			max_rate = MAX_RATE_RESET;
			mismatches = 0;
			for (int d = 0; d < 2; d++) begin
				empty_flag[d] = 0;
				reflecting[d] = 0;
				cur_cnt[d] = 0;
				prev_cnt[d] = 0;
				lost_cnt[d] = 0;
				mark_cnt[d] = 0;
				gen_cnt[d] = 0;
				ring_ptr[d] = 0;
				total_q[d] = 0;
				avg_q[d] = 0;
				for (int i = 0; i < HDEPTH; i++) ring[d][i] = 0;
			end
		endfunction

		function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? CNT_MAX : s[31:0];
		endfunction

		function logic [RATE_W-1:0] fraction(logic [31:0] num, logic [31:0] den);
			logic [63:0] q;
			if (den == 0) return (num != 0) ? RATE_ONE : '0;
			if (num >= den) return RATE_ONE;
			q = ({32'd0, num} << FRAC_BITS) / {32'd0, den};
			return q[RATE_W-1:0];
		endfunction

		function logic [RATE_W-1:0] ring_average(int d);
			logic [31:0] sum;
			int n;
			sum = 0;
			n = 0;
			for (int i = 0; i < HDEPTH; i++) begin
				if (ring[d][i] < max_rate) begin
					sum += ring[d][i];
					n++;
				end
			end
			if (n == 0) return '0;
			return RATE_W'(sum / n);
		endfunction

		// Notes an accepted packet and queues the result it must produce.
		function void note_packet(in_item_t pkt);
			int d;
			logic [1:0] ev;
			logic [31:0] prv, cur, losses;
			out_item_t r;
			d = pkt.direction;
			ev = EV_NONE;
			if (pkt.spin_flip) begin
				if (empty_flag[d]) begin
					if (cur_cnt[d] > 0) begin
						prv = prev_cnt[d];
						cur = cur_cnt[d];
						if (reflecting[d]) begin
							if (prv < cur) begin
								lost_cnt[d] = sat_sum(lost_cnt[d], prv);
								total_q[d] = fraction(lost_cnt[d], mark_cnt[d]);
								if (prv > 0) reflecting[d] = 0;
								ev = EV_TOTAL;
							end else begin
								losses = prv - cur;
								lost_cnt[d] = sat_sum(lost_cnt[d], losses);
								gen_cnt[d] = sat_sum(gen_cnt[d], prv);
								ring[d][ring_ptr[d]] = fraction(losses, prv);
								ring_ptr[d] = (ring_ptr[d] + 1) % HDEPTH;
								total_q[d] = fraction(lost_cnt[d], gen_cnt[d]);
								avg_q[d] = ring_average(d);
								ev = EV_FULL;
							end
						end
						prev_cnt[d] = cur;
						cur_cnt[d] = 0;
						reflecting[d] = !reflecting[d];
					end
				end else begin
					empty_flag[d] = 1;
				end
			end
			if (pkt.loss_bit) begin
				mark_cnt[d] = sat_sum(mark_cnt[d], 1);
				cur_cnt[d] = sat_sum(cur_cnt[d], 1);
				empty_flag[d] = 0;
			end
			r.event_res = ev;
			r.out_direction = pkt.direction;
			r.total_loss_rate = total_q[d];
			r.average_loss_rate = avg_q[d];
			pending.push_back(r);
		endfunction

		// Compares one result with the oldest expectation.
		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got.event_res !== exp_r.event_res ||
			    got.out_direction !== exp_r.out_direction ||
			    got.total_loss_rate !== exp_r.total_loss_rate ||
			    got.average_loss_rate !== exp_r.average_loss_rate) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected ev=%0d dir=%0d total=%0d avg=%0d, got ev=%0d dir=%0d total=%0d avg=%0d",
						exp_r.event_res, exp_r.out_direction, exp_r.total_loss_rate,
						exp_r.average_loss_rate, got.event_res, got.out_direction,
						got.total_loss_rate, got.average_loss_rate);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [RATE_W-1:0] cfg_data = '0;

	loss_scoreboard sb;
	int idle_cycles = 0;
	bit sink_on = 0;

	round_trip_loss_bit_tracker i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	// Result side: checks transfers, stalls at random, runs the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("round_trip_loss_bit_tracker verification failed");
				$finish;
			end
		end
	end

	initial begin : sink
		int g;
		wait (sink_on);
		forever begin
			@(posedge clk);
			out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
			g = gap_len();
			if (g > 0) begin
				out_ready <= 0;
				repeat (g - 1) @(posedge clk);
			end
		end
	end

	// Sends one packet and notes it when the transfer happens.
	task automatic send_packet(bit d, bit f, bit m);
		in_item_t p;
		int g;
		p.direction = d;
		p.spin_flip = f;
		p.loss_bit = m;
		in_valid <= 1;
		in_data <= p;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_packet(p);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Waits for all expected results plus the longest processing time.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_max_rate(logic [RATE_W-1:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.max_rate = v;
		cfg_valid <= 0;
	endtask

	// One spin period: a flip, then a run of marked or unmarked packets.
	task automatic send_period(bit d, int marks);
		send_packet(d, 1, $urandom_range(0, 3) == 0);
		for (int i = 0; i < marks; i++) send_packet(d, 0, $urandom_range(0, 4) != 0);
	endtask

	initial begin
		logic [RATE_W-1:0] rates[5];
		int n;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		sink_on = 1;
		@(posedge clk);

		// Directed: all field combinations, then periods that lose and gain marks.
		for (int i = 0; i < 8; i++) send_packet(i[2], i[1], i[0]);
		for (int d = 0; d < 2; d++) begin
			send_packet(d, 1, 0);
			send_packet(d, 0, 1); send_packet(d, 0, 1); send_packet(d, 0, 1);
			send_packet(d, 1, 0); send_packet(d, 1, 0);
			send_packet(d, 0, 1);
			send_packet(d, 1, 0); send_packet(d, 1, 0);
		end
		send_packet(0, 1, 1);
		drain();

		rates[0] = 17'd0; rates[1] = 17'h10000; rates[2] = 17'd20000;
		rates[3] = 17'd1; rates[4] = 17'h1FFFF;
		for (int ph = 0; ph < 5; ph++) begin
			write_max_rate(rates[ph]);
			n = 0;
			while (n < 360) begin
				if ($urandom_range(0, 9) == 0) begin
					send_packet($urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 1));
					n++;
				end else begin
					int marks;
					marks = $urandom_range(0, 9) == 0 ? $urandom_range(10, 30)
						: $urandom_range(0, 6);
					send_period($urandom_range(0, 1), marks);
					n += marks + 1;
				end
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("round_trip_loss_bit_tracker verification clean");
		end else begin
			$display("round_trip_loss_bit_tracker verification failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/rtlt_pkg.sv
sv/rtlt_div.sv
sv/rtlt_ctrl.sv
sv/rtlt_dp.sv
sv/round_trip_loss_bit_tracker.sv
verif/round_trip_loss_bit_tracker_tb.sv
